>>> hw/rtl/tmq_pkg.sv
package tmq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int KIND_W    = 15;
  localparam int SEL_W     = 16;
  localparam int LEN_W     = 12;
  localparam int PAYLOAD_W = 32;
  localparam int CAP_W     = 5;
  localparam int COUNT_W   = 5;
  localparam int STATUS_W  = 2;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [LEN_W-1:0] MAX_LEN_RST = 12'd4095;
  localparam logic [CAP_W-1:0] CAP_RST     = 5'd16;

  // register index decoded from paddr[2]
  localparam logic REG_MAX_LEN = 1'b0;
  localparam logic REG_CAP     = 1'b1;

  localparam logic REQ_SEND = 1'b0;
  localparam logic REQ_RECV = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic evaluate;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0] max_len;
    logic [CAP_W-1:0] cap;
  } cfg_t;

endpackage

>>> hw/rtl/typed_message_queue_top.sv
// A request beat is registered when taken, evaluated (match vector over all
// entries) and then committed (select, compact and count update), and its
// result is registered at commit, which waits while the result slot is full.
// A new request is taken in the commit cycle when the result slot is free.
// Reset (rst_n, synchronous, active low) empties the queue, clears the
// handshake state and restores both registers; entry contents are not cleared.
module typed_message_queue_top #(
  parameter int QUEUE_DEPTH = tmq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_req_type,
  input  logic [tmq_pkg::KIND_W-1:0]           in_message_kind,
  input  logic signed [tmq_pkg::SEL_W-1:0]     in_kind_selector,
  input  logic [tmq_pkg::LEN_W-1:0]            in_length,
  input  logic [tmq_pkg::PAYLOAD_W-1:0]        in_payload_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tmq_pkg::STATUS_W-1:0]         out_status,
  output logic [tmq_pkg::KIND_W-1:0]           out_kind,
  output logic [tmq_pkg::LEN_W-1:0]            out_length,
  output logic [tmq_pkg::PAYLOAD_W-1:0]        out_payload,
  output logic [tmq_pkg::COUNT_W-1:0]          out_message_count,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tmq_pkg::PADDR_W-1:0]          paddr,
  input  logic [tmq_pkg::PDATA_W-1:0]          pwdata,
  output logic [tmq_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready
);

  tmq_pkg::cmd_t cmd;
  tmq_pkg::cfg_t cfg;

  tmq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tmq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg               (cfg),
    .in_req_type       (in_req_type),
    .in_message_kind   (in_message_kind),
    .in_kind_selector  (in_kind_selector),
    .in_length         (in_length),
    .in_payload_word   (in_payload_word),
    .out_status        (out_status),
    .out_kind          (out_kind),
    .out_length        (out_length),
    .out_payload       (out_payload),
    .out_message_count (out_message_count)
  );

endmodule

>>> hw/rtl/tmq_cfg.sv
module tmq_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tmq_pkg::PADDR_W-1:0]   paddr,
  input  logic [tmq_pkg::PDATA_W-1:0]   pwdata,
  output logic [tmq_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output tmq_pkg::cfg_t                 cfg
);

  logic [tmq_pkg::LEN_W-1:0] max_len_r;
  logic [tmq_pkg::CAP_W-1:0] cap_r;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= tmq_pkg::MAX_LEN_RST;
      cap_r     <= tmq_pkg::CAP_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        tmq_pkg::REG_MAX_LEN: max_len_r <= pwdata[tmq_pkg::LEN_W-1:0];
        tmq_pkg::REG_CAP:     cap_r     <= pwdata[tmq_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tmq_pkg::REG_MAX_LEN: prdata = tmq_pkg::PDATA_W'(max_len_r);
      tmq_pkg::REG_CAP:     prdata = tmq_pkg::PDATA_W'(cap_r);
      default:              prdata = '0;
    endcase
  end

  assign cfg.max_len = max_len_r;
  assign cfg.cap     = cap_r;

endmodule

>>> hw/rtl/tmq_ctrl.sv
module tmq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output tmq_pkg::cmd_t cmd
);

  tmq_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            room;

  // result slot is free this cycle, or is being drained
  assign room = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tmq_pkg::ST_IDLE: if (in_valid) state_nxt = tmq_pkg::ST_EVAL;
      tmq_pkg::ST_EVAL: state_nxt = tmq_pkg::ST_EXEC;
      tmq_pkg::ST_EXEC: begin
        if (room) state_nxt = in_valid ? tmq_pkg::ST_EVAL : tmq_pkg::ST_IDLE;
      end
      default: state_nxt = tmq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.evaluate = 1'b0;
    cmd.commit   = 1'b0;
    unique case (state_r)
      tmq_pkg::ST_IDLE: in_ready = 1'b1;
      tmq_pkg::ST_EVAL: cmd.evaluate = 1'b1;
      tmq_pkg::ST_EXEC: begin
        in_ready   = room;
        cmd.commit = room;
      end
      default: ;
    endcase
    cmd.capture   = in_valid && in_ready;
    out_valid_nxt = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_capture_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == tmq_pkg::ST_EVAL)
    else $error("beat taken but evaluation not started");

  a_eval_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tmq_pkg::ST_EVAL |=> state_r == tmq_pkg::ST_EXEC)
    else $error("evaluation not followed by execute");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit did not present a result beat");
`endif

endmodule

>>> hw/rtl/tmq_dp.sv
module tmq_dp #(
  parameter int QUEUE_DEPTH = tmq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tmq_pkg::cmd_t                        cmd,
  input  tmq_pkg::cfg_t                        cfg,
  input  logic                                 in_req_type,
  input  logic [tmq_pkg::KIND_W-1:0]           in_message_kind,
  input  logic signed [tmq_pkg::SEL_W-1:0]     in_kind_selector,
  input  logic [tmq_pkg::LEN_W-1:0]            in_length,
  input  logic [tmq_pkg::PAYLOAD_W-1:0]        in_payload_word,
  output logic [tmq_pkg::STATUS_W-1:0]         out_status,
  output logic [tmq_pkg::KIND_W-1:0]           out_kind,
  output logic [tmq_pkg::LEN_W-1:0]            out_length,
  output logic [tmq_pkg::PAYLOAD_W-1:0]        out_payload,
  output logic [tmq_pkg::COUNT_W-1:0]          out_message_count
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > tmq_pkg::CAP_W) ? CNT_W : tmq_pkg::CAP_W;
  localparam int MAG_W = tmq_pkg::SEL_W + 1;
  localparam logic [MAG_W-1:0] MAG_WRAP = MAG_W'(1) << tmq_pkg::SEL_W;

  // request held across evaluate and commit
  logic                            req_type_r;
  logic [tmq_pkg::KIND_W-1:0]      req_kind_r;
  logic [tmq_pkg::SEL_W-1:0]       req_sel_r;
  logic [tmq_pkg::LEN_W-1:0]       req_len_r;
  logic [tmq_pkg::PAYLOAD_W-1:0]   req_payload_r;

  // store, kept in arrival order
  logic [tmq_pkg::KIND_W-1:0]      kind_mem_r    [QUEUE_DEPTH];
  logic [tmq_pkg::LEN_W-1:0]       len_mem_r     [QUEUE_DEPTH];
  logic [tmq_pkg::PAYLOAD_W-1:0]   payload_mem_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]                count_r, count_nxt;

  // evaluate stage
  logic                            sel_neg, sel_zero;
  logic [MAG_W-1:0]                mag;
  logic [QUEUE_DEPTH-1:0]          hit_nxt, hit_r;
  logic                            too_long, full, short_buf, found;
  logic [tmq_pkg::STATUS_W-1:0]    status_nxt, status_r;
  logic                            send_ok_nxt, send_ok_r;
  logic                            recv_ok_nxt, recv_ok_r;

  // commit stage
  logic [QUEUE_DEPTH-1:0]          hit_neg, onehot, shift_mask;
  logic [tmq_pkg::KIND_W-1:0]      pick_kind;
  logic [tmq_pkg::LEN_W-1:0]       pick_len;
  logic [tmq_pkg::PAYLOAD_W-1:0]   pick_payload;
  logic [IDX_W-1:0]                wr_idx;

  logic [tmq_pkg::STATUS_W-1:0]    out_status_r;
  logic [tmq_pkg::KIND_W-1:0]      out_kind_r;
  logic [tmq_pkg::LEN_W-1:0]       out_len_r;
  logic [tmq_pkg::PAYLOAD_W-1:0]   out_payload_r;
  logic [tmq_pkg::COUNT_W-1:0]     out_count_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_r    <= in_req_type;
      req_kind_r    <= in_message_kind;
      req_sel_r     <= in_kind_selector;
      req_len_r     <= in_length;
      req_payload_r <= in_payload_word;
    end
  end

  always_comb begin
    sel_neg  = req_sel_r[tmq_pkg::SEL_W-1];
    sel_zero = (req_sel_r == '0);
    // magnitude of a negative selector; -32768 gives 32768
    mag      = sel_neg ? MAG_WRAP - {1'b0, req_sel_r} : {1'b0, req_sel_r};
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit_nxt[i] = (CNT_W'(i) < count_r) &&
                   (sel_zero ||
                    (sel_neg ? (MAG_W'(kind_mem_r[i]) < mag)
                             : (kind_mem_r[i] == req_sel_r[tmq_pkg::KIND_W-1:0])));
    end
    too_long  = req_len_r > cfg.max_len;
    full      = (CMP_W'(count_r) >= CMP_W'(cfg.cap)) ||
                (count_r == CNT_W'(QUEUE_DEPTH));
    // buffer check only applies to the oldest-message mode on a non-empty queue
    short_buf = sel_zero && (count_r != '0) && (req_len_r < len_mem_r[0]);
    found     = |hit_nxt;

    send_ok_nxt = 1'b0;
    recv_ok_nxt = 1'b0;
    if (req_type_r == tmq_pkg::REQ_SEND) begin
      if (too_long) begin
        status_nxt = tmq_pkg::STATUS_TOO_LONG;
      end else if (full) begin
        status_nxt = tmq_pkg::STATUS_FULL;
      end else begin
        status_nxt  = tmq_pkg::STATUS_OK;
        send_ok_nxt = 1'b1;
      end
    end else begin
      if (short_buf) begin
        status_nxt = tmq_pkg::STATUS_TOO_LONG;
      end else if (!found) begin
        status_nxt = tmq_pkg::STATUS_NONE;
      end else begin
        status_nxt  = tmq_pkg::STATUS_OK;
        recv_ok_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.evaluate) begin
      hit_r     <= hit_nxt;
      status_r  <= status_nxt;
      send_ok_r <= send_ok_nxt;
      recv_ok_r <= recv_ok_nxt;
    end
  end

  // x & -x isolates the oldest hit, x | -x marks it and everything above
  always_comb begin
    hit_neg      = ~hit_r + QUEUE_DEPTH'(1);
    onehot       = hit_r & hit_neg;
    shift_mask   = hit_r | hit_neg;
    pick_kind    = '0;
    pick_len     = '0;
    pick_payload = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      pick_kind    = pick_kind    | ({tmq_pkg::KIND_W{onehot[i]}}    & kind_mem_r[i]);
      pick_len     = pick_len     | ({tmq_pkg::LEN_W{onehot[i]}}     & len_mem_r[i]);
      pick_payload = pick_payload | ({tmq_pkg::PAYLOAD_W{onehot[i]}} & payload_mem_r[i]);
    end
    wr_idx = count_r[IDX_W-1:0];
    if (send_ok_r) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (recv_ok_r) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (recv_ok_r) begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          if (shift_mask[i]) begin
            kind_mem_r[i]    <= kind_mem_r[i+1];
            len_mem_r[i]     <= len_mem_r[i+1];
            payload_mem_r[i] <= payload_mem_r[i+1];
          end
        end
      end
      if (send_ok_r) begin
        kind_mem_r[wr_idx]    <= req_kind_r;
        len_mem_r[wr_idx]     <= req_len_r;
        payload_mem_r[wr_idx] <= req_payload_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r  <= status_r;
      out_kind_r    <= recv_ok_r ? pick_kind    : '0;
      out_len_r     <= recv_ok_r ? pick_len     : '0;
      out_payload_r <= recv_ok_r ? pick_payload : '0;
      out_count_r   <= tmq_pkg::COUNT_W'(count_nxt);
    end
  end

  assign out_status        = out_status_r;
  assign out_kind          = out_kind_r;
  assign out_length        = out_len_r;
  assign out_payload       = out_payload_r;
  assign out_message_count = out_count_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("message count beyond store depth");

  a_recv_has_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && recv_ok_r |-> $onehot(onehot))
    else $error("receive committed without a single selected entry");

  a_recv_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && recv_ok_r |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("receive did not remove exactly one message");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tmq_pkg::*;

  localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic {ROW_BEAT, ROW_CONFIG} row_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [KIND_W-1:0]    kind;
    logic [LEN_W-1:0]     length;
    logic [PAYLOAD_W-1:0] payload;
    logic [COUNT_W-1:0]   count;
  } mailbox_result_t;

  typedef struct {
    logic [KIND_W-1:0]    kind;
    logic [LEN_W-1:0]     length;
    logic [PAYLOAD_W-1:0] payload;
  } held_msg_t;

  typedef struct {
    row_op_t                 op;
    logic                    reg_idx;
    logic                    req;
    logic [KIND_W-1:0]       kind;
    logic signed [SEL_W-1:0] sel;
    logic [LEN_W-1:0]        len;
    logic [PAYLOAD_W-1:0]    pay;
    bit                      has_golden;
    mailbox_result_t         golden;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, in_req_type;
  logic [KIND_W-1:0] in_message_kind;
  logic signed [SEL_W-1:0] in_kind_selector;
  logic [LEN_W-1:0] in_length;
  logic [PAYLOAD_W-1:0] in_payload_word;
  logic out_valid, out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [KIND_W-1:0] out_kind;
  logic [LEN_W-1:0] out_length;
  logic [PAYLOAD_W-1:0] out_payload;
  logic [COUNT_W-1:0] out_message_count;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic pready;

  // golden value riding along with a directed beat
  bit row_checked;
  mailbox_result_t row_golden;

  // predictor state
  held_msg_t held_msgs[$];
  logic [LEN_W-1:0] max_len_cfg = MAX_LEN_RST;
  logic [CAP_W-1:0] cap_cfg = CAP_RST;

  mailbox_result_t pending_results[$];
  directed_row_t directed_rows[$];
  int mismatch_count = 0;
  int burst_left = 0;
  logic [31:0] cycle_count = 0;

  typed_message_queue_top #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_message_kind(in_message_kind), .in_kind_selector(in_kind_selector),
    .in_length(in_length), .in_payload_word(in_payload_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_kind(out_kind), .out_length(out_length), .out_payload(out_payload),
    .out_message_count(out_message_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: cycles through full rate, light, periodic long and heavy stalls
  always @(posedge clk) begin
    case (cycle_count[10:9])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_ready <= (cycle_count[3:0] < 4'd5);
      default: out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  function automatic mailbox_result_t result_of(input logic [STATUS_W-1:0] st,
      input logic [KIND_W-1:0] k, input logic [LEN_W-1:0] l,
      input logic [PAYLOAD_W-1:0] p, input logic [COUNT_W-1:0] c);
    mailbox_result_t res;
    res.status = st;
    res.kind = k;
    res.length = l;
    res.payload = p;
    res.count = c;
    return res;
  endfunction

  function automatic mailbox_result_t serve_request(input logic req,
      input logic [KIND_W-1:0] kind, input logic signed [SEL_W-1:0] sel,
      input logic [LEN_W-1:0] len, input logic [PAYLOAD_W-1:0] pay);
    mailbox_result_t res;
    held_msg_t msg;
    int limit;
    int mag;
    int hit;
    res = '0;
    hit = -1;
    limit = (cap_cfg > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(cap_cfg);
    if (req == REQ_SEND) begin
      // length check wins over the full check
      if (len > max_len_cfg) begin
        res.status = STATUS_TOO_LONG;
      end else if (held_msgs.size() >= limit) begin
        res.status = STATUS_FULL;
      end else begin
        msg.kind = kind;
        msg.length = len;
        msg.payload = pay;
        held_msgs.push_back(msg);
      end
    end else if (held_msgs.size() == 0) begin
      res.status = STATUS_NONE;
    end else begin
      if (sel == 0) begin
        // buffer length only matters for the take-oldest mode
        if (len < held_msgs[0].length) res.status = STATUS_TOO_LONG;
        else hit = 0;
      end else begin
        mag = (sel < 0) ? -int'(sel) : int'(sel);
        foreach (held_msgs[i]) begin
          if (hit < 0 && ((sel < 0) ? (held_msgs[i].kind < mag)
                                    : (held_msgs[i].kind == mag))) hit = i;
        end
        if (hit < 0) res.status = STATUS_NONE;
      end
      if (hit >= 0) begin
        res.kind = held_msgs[hit].kind;
        res.length = held_msgs[hit].length;
        res.payload = held_msgs[hit].payload;
        held_msgs.delete(hit);
      end
    end
    res.count = held_msgs.size();
    return res;
  endfunction

  always @(posedge clk) begin : result_check
    mailbox_result_t got;
    mailbox_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = result_of(out_status, out_kind, out_length, out_payload, out_message_count);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: status %0d kind %h length %0d payload %h count %0d",
                   got.status, got.kind, got.length, got.payload, got.count);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.kind !== want.kind ||
            got.length !== want.length || got.payload !== want.payload ||
            got.count !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch (exp/got): status %0d/%0d kind %h/%h length %0d/%0d",
                      " payload %h/%h count %0d/%0d"},
                     want.status, got.status, want.kind, got.kind, want.length,
                     got.length, want.payload, got.payload, want.count, got.count);
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      want = serve_request(in_req_type, in_message_kind, in_kind_selector,
                           in_length, in_payload_word);
      pending_results.push_back(row_checked ? row_golden : want);
    end
  end

  task automatic stage_beat(input logic req, input logic [KIND_W-1:0] kind,
      input logic signed [SEL_W-1:0] sel, input logic [LEN_W-1:0] len,
      input logic [PAYLOAD_W-1:0] pay, input bit checked, input mailbox_result_t golden);
    directed_row_t row;
    row.op = ROW_BEAT;
    row.reg_idx = REG_MAX_LEN;
    row.req = req;
    row.kind = kind;
    row.sel = sel;
    row.len = len;
    row.pay = pay;
    row.has_golden = checked;
    row.golden = golden;
    directed_rows.push_back(row);
  endtask

  task automatic stage_config(input logic idx, input logic [PDATA_W-1:0] value);
    directed_row_t row;
    row.op = ROW_CONFIG;
    row.reg_idx = idx;
    row.req = REQ_SEND;
    row.kind = '0;
    row.sel = '0;
    row.len = '0;
    row.pay = value;
    row.has_golden = 1'b0;
    row.golden = '0;
    directed_rows.push_back(row);
  endtask

  task automatic post_request(input logic req, input logic [KIND_W-1:0] kind,
      input logic signed [SEL_W-1:0] sel, input logic [LEN_W-1:0] len,
      input logic [PAYLOAD_W-1:0] pay, input bit checked, input mailbox_result_t golden);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_message_kind <= kind;
    in_kind_selector <= sel;
    in_length <= len;
    in_payload_word <= pay;
    row_checked <= checked;
    row_golden <= golden;
    do @(posedge clk); while (!in_ready);
  endtask

  // bursts of random length, random gaps, now and then a long steady stretch
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(0, 24);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic await_quiet();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // return the bus to idle so a following write starts in a later step
    @(posedge clk);
    if (idx == REG_MAX_LEN) max_len_cfg = value[LEN_W-1:0];
    else cap_cfg = value[CAP_W-1:0];
  endtask

  initial begin : stimulus
    logic req;
    logic [KIND_W-1:0] kind;
    logic signed [SEL_W-1:0] sel;
    logic [LEN_W-1:0] len;
    logic [PAYLOAD_W-1:0] pay;
    int r;
    int phase_items;
    int next_max;
    int next_cap;
    int tide_left;
    bit filling;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_SEND;
    in_message_kind = '0;
    in_kind_selector = '0;
    in_length = '0;
    in_payload_word = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    row_checked = 1'b0;
    row_golden = '0;

    // empty queue, extremes, every selector mode
    stage_beat(REQ_RECV, 15'd0, 16'sd0, 12'd0, 32'd0, 1'b1,
               result_of(STATUS_NONE, 0, 0, 0, 0));
    stage_beat(REQ_RECV, 15'd0, 16'sh8000, 12'd4095, 32'd0, 1'b1,
               result_of(STATUS_NONE, 0, 0, 0, 0));
    stage_beat(REQ_SEND, 15'd0, 16'sd0, 12'd0, 32'd0, 1'b1,
               result_of(STATUS_OK, 0, 0, 0, 1));
    stage_beat(REQ_SEND, 15'h7fff, 16'sh7fff, 12'd4095, 32'hffff_ffff, 1'b1,
               result_of(STATUS_OK, 0, 0, 0, 2));
    stage_beat(REQ_RECV, 15'h7fff, 16'sd0, 12'd0, 32'hffff_ffff, 1'b1,
               result_of(STATUS_OK, 0, 0, 0, 1));
    stage_beat(REQ_SEND, 15'd5, 16'sd0, 12'd100, 32'ha5a5_a5a5, 1'b0, '0);
    // oldest is 4095 long, buffer one short
    stage_beat(REQ_RECV, 15'd0, 16'sd0, 12'd4094, 32'd0, 1'b1,
               result_of(STATUS_TOO_LONG, 0, 0, 0, 2));
    stage_beat(REQ_RECV, 15'd0, 16'sd7, 12'd4095, 32'd0, 1'b1,
               result_of(STATUS_NONE, 0, 0, 0, 2));
    stage_beat(REQ_RECV, 15'd0, 16'sd5, 12'd0, 32'd0, 1'b1,
               result_of(STATUS_OK, 5, 100, 32'ha5a5_a5a5, 1));
    stage_beat(REQ_SEND, 15'd3, 16'sd0, 12'd7, 32'h1234_5678, 1'b0, '0);
    stage_beat(REQ_RECV, 15'd0, -16'sd4, 12'd0, 32'd0, 1'b1,
               result_of(STATUS_OK, 3, 7, 32'h1234_5678, 1));
    stage_beat(REQ_RECV, 15'd0, 16'sh8000, 12'd0, 32'd0, 1'b1,
               result_of(STATUS_OK, 15'h7fff, 12'd4095, 32'hffff_ffff, 0));
    stage_beat(REQ_RECV, 15'd0, 16'sh7fff, 12'd4095, 32'd0, 1'b1,
               result_of(STATUS_NONE, 0, 0, 0, 0));
    // zero length limit and zero capacity
    stage_config(REG_MAX_LEN, 32'd0);
    stage_config(REG_CAP, 32'd0);
    stage_beat(REQ_SEND, 15'd1, 16'sd0, 12'd1, 32'd1, 1'b1,
               result_of(STATUS_TOO_LONG, 0, 0, 0, 0));
    stage_beat(REQ_SEND, 15'd1, 16'sd0, 12'd0, 32'd1, 1'b1,
               result_of(STATUS_FULL, 0, 0, 0, 0));
    // fill, then lower capacity below the count
    stage_config(REG_MAX_LEN, 32'd4095);
    stage_config(REG_CAP, 32'd2);
    stage_beat(REQ_SEND, 15'd9, 16'sd0, 12'd10, 32'h0f0f_0f0f, 1'b0, '0);
    stage_beat(REQ_SEND, 15'h4000, 16'sd0, 12'd20, 32'hf0f0_f0f0, 1'b0, '0);
    stage_beat(REQ_SEND, 15'd1, 16'sd0, 12'd0, 32'd2, 1'b1,
               result_of(STATUS_FULL, 0, 0, 0, 2));
    stage_config(REG_CAP, 32'd1);
    stage_beat(REQ_SEND, 15'd1, 16'sd0, 12'd0, 32'd3, 1'b1,
               result_of(STATUS_FULL, 0, 0, 0, 2));
    stage_beat(REQ_RECV, 15'd0, 16'sd0, 12'd4095, 32'd0, 1'b0, '0);
    stage_beat(REQ_SEND, 15'd1, 16'sd0, 12'd0, 32'd4, 1'b1,
               result_of(STATUS_FULL, 0, 0, 0, 1));
    stage_beat(REQ_RECV, 15'd0, 16'sh8000, 12'd0, 32'd0, 1'b1,
               result_of(STATUS_OK, 15'h4000, 12'd20, 32'hf0f0_f0f0, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_CONFIG) begin
        await_quiet();
        write_register(directed_rows[i].reg_idx, directed_rows[i].pay);
      end else begin
        post_request(directed_rows[i].req, directed_rows[i].kind, directed_rows[i].sel,
                     directed_rows[i].len, directed_rows[i].pay,
                     directed_rows[i].has_golden, directed_rows[i].golden);
        pace_sender();
      end
    end

    tide_left = 0;
    filling = 1'b1;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin next_max = 4095; next_cap = 16; phase_items = 200; end
        1: begin next_max = $urandom_range(0, 4095); next_cap = 31; phase_items = 200; end
        2: begin next_max = 4095; next_cap = 1; phase_items = 120; end
        3: begin next_max = 0; next_cap = 16; phase_items = 100; end
        4: begin
          next_max = $urandom_range(1, 4094);
          next_cap = $urandom_range(2, 15);
          phase_items = 200;
        end
        5: begin next_max = 4095; next_cap = 0; phase_items = 30; end
        default: begin next_max = 4095; next_cap = 16; phase_items = 180; end
      endcase
      await_quiet();
      write_register(REG_MAX_LEN, next_max);
      write_register(REG_CAP, next_cap);

      for (int n = 0; n < phase_items; n++) begin
        if (phase == 0 && n == 100) await_quiet();
        // alternate fill and drain stretches so the queue sweeps its range
        if (tide_left == 0) begin
          filling = !filling;
          tide_left = $urandom_range(6, 30);
        end
        tide_left--;
        req = ($urandom_range(0, 99) < (filling ? 80 : 25)) ? REQ_SEND : REQ_RECV;

        r = $urandom_range(0, 9);
        if (r < 7) kind = $urandom_range(0, 7);
        else if (r == 7) kind = 15'h7fff;
        else kind = $urandom;

        r = $urandom_range(0, 9);
        if (r < 4) sel = 16'sd0;
        else if (r < 6) sel = $urandom_range(1, 8);
        else if (r < 8) sel = -$urandom_range(1, 9);
        else if (r == 8) sel = $urandom;
        else sel = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7fff;

        r = $urandom_range(0, 9);
        if (req == REQ_SEND) begin
          if (r < 7) len = $urandom_range(0, max_len_cfg);
          else if (r == 7) len = 12'd4095;
          else len = $urandom;
        end else begin
          if (r < 5) len = 12'd4095;
          else if (r < 8) len = $urandom;
          else len = $urandom_range(0, 15);
        end

        pay = $urandom;
        post_request(req, kind, sel, len, pay, 1'b0, '0);
        pace_sender();
      end
    end

    await_quiet();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/tmq_pkg.sv
hw/rtl/tmq_cfg.sv
hw/rtl/tmq_ctrl.sv
hw/rtl/tmq_dp.sv
hw/rtl/typed_message_queue_top.sv
bench/testbench.sv
